// ===== rtl/core/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression unit.
`default_nettype none
package gbs_pkg;

  // Field widths
  localparam int SCORE_W = 16;
  localparam int EDGE_W  = 16;
  localparam int BOX_W   = 4 * EDGE_W;
  localparam int DIFF_W  = EDGE_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int UNI_W   = PROD_W + 2;
  localparam int LO_W    = 18;
  localparam int HI_W    = UNI_W - LO_W;
  localparam int PLO_W   = SCORE_W + LO_W;
  localparam int PHI_W   = SCORE_W + 1 + HI_W;
  localparam int CMP_W   = 54;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_IOU_THRESHOLD = 1'b0;
  localparam logic [SCORE_W-1:0] IOU_THRESHOLD_RESET = 16'd26214;

  // Controller states
  typedef enum logic [3:0] {
    S_LOAD,
    S_SEL_SCAN,
    S_SEL_DRAIN,
    S_SEL_DONE,
    S_FETCH,
    S_LOAD_A,
    S_AREA,
    S_SUPP_SCAN,
    S_SUPP_DRAIN,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_box;
    logic set_ovf;
    logic sel_issue;
    logic supp_issue;
    logic rd_best;
    logic clear_best;
    logic load_a;
    logic area_step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic best_found;
    logic supp_busy;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gbs_if.sv =====
// Channel interfaces: input boxes and kept results.
`default_nettype none
interface gbs_box_if;
  logic        valid;
  logic        ready;
  logic [15:0] score;
  logic signed [15:0] x_min;
  logic signed [15:0] y_min;
  logic signed [15:0] x_max;
  logic signed [15:0] y_max;
  logic        final_box;

  modport source (output valid, score, x_min, y_min, x_max, y_max, final_box,
                  input ready);
  modport sink   (input valid, score, x_min, y_min, x_max, y_max, final_box,
                  output ready);
endinterface

interface gbs_kept_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_score;
  logic signed [15:0] kept_x_min;
  logic signed [15:0] kept_y_min;
  logic signed [15:0] kept_x_max;
  logic signed [15:0] kept_y_max;
  logic        last_kept;
  logic        none_kept;
  logic        overflowed;

  modport source (output valid, kept_score, kept_x_min, kept_y_min, kept_x_max,
                  kept_y_max, last_kept, none_kept, overflowed, input ready);
  modport sink   (input valid, kept_score, kept_x_min, kept_y_min, kept_x_max,
                  kept_y_max, last_kept, none_kept, overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gbs_ctrl.sv =====
// Controller: load, select, suppress and finish sequencing.
`default_nettype none
module gbs_ctrl #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic                               in_final,
  output logic                                    in_ready,
  input  wire gbs_pkg::status_t                   status,
  output gbs_pkg::cmd_t                           cmd,
  output logic [$clog2(MAX_BOXES)-1:0]            wr_idx,
  output logic [$clog2(MAX_BOXES)-1:0]            rd_idx
);
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  gbs_pkg::state_t state, state_next;
  logic [CNT_W-1:0] box_count;
  logic [CNT_W-1:0] scan;
  logic             accept;
  logic             full;
  logic             scan_last;

  assign accept    = (state == gbs_pkg::S_LOAD) && in_valid;
  assign full      = (box_count == CNT_W'(MAX_BOXES));
  assign scan_last = (scan == box_count - CNT_W'(1));
  assign wr_idx    = box_count[IDX_W-1:0];
  assign rd_idx    = scan[IDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbs_pkg::S_LOAD:       if (accept && in_final) state_next = gbs_pkg::S_SEL_SCAN;
      gbs_pkg::S_SEL_SCAN:   if (scan_last) state_next = gbs_pkg::S_SEL_DRAIN;
      gbs_pkg::S_SEL_DRAIN:  state_next = gbs_pkg::S_SEL_DONE;
      gbs_pkg::S_SEL_DONE: begin
        if (!status.best_found) state_next = gbs_pkg::S_FINISH;
        else if (!status.out_busy) state_next = gbs_pkg::S_FETCH;
      end
      gbs_pkg::S_FETCH:      state_next = gbs_pkg::S_LOAD_A;
      gbs_pkg::S_LOAD_A:     state_next = gbs_pkg::S_AREA;
      gbs_pkg::S_AREA:       state_next = gbs_pkg::S_SUPP_SCAN;
      gbs_pkg::S_SUPP_SCAN:  if (scan_last) state_next = gbs_pkg::S_SUPP_DRAIN;
      gbs_pkg::S_SUPP_DRAIN: if (!status.supp_busy) state_next = gbs_pkg::S_SEL_SCAN;
      gbs_pkg::S_FINISH:     if (!status.out_busy) state_next = gbs_pkg::S_LOAD;
      default:               state_next = gbs_pkg::S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      gbs_pkg::S_LOAD: begin
        in_ready    = 1'b1;
        cmd.wr_box  = accept && !full;
        cmd.set_ovf = accept && full;
      end
      gbs_pkg::S_SEL_SCAN:  cmd.sel_issue = 1'b1;
      gbs_pkg::S_FETCH: begin
        cmd.rd_best    = 1'b1;
        cmd.clear_best = 1'b1;
      end
      gbs_pkg::S_LOAD_A:    cmd.load_a = 1'b1;
      gbs_pkg::S_AREA:      cmd.area_step = 1'b1;
      gbs_pkg::S_SUPP_SCAN: cmd.supp_issue = 1'b1;
      gbs_pkg::S_FINISH:    cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

  // State, box count and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbs_pkg::S_LOAD;
      box_count <= '0;
      scan      <= '0;
    end else begin
      state <= state_next;
      if (cmd.wr_box) box_count <= box_count + CNT_W'(1);
      if (cmd.finish) box_count <= '0;
      if (state_next != state) scan <= '0;
      else if (cmd.sel_issue || cmd.supp_issue) scan <= scan + CNT_W'(1);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/gbs_datapath.sv =====
// Datapath: box memories, best-score search, overlap pipeline, result register.
`default_nettype none
module gbs_datapath #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire gbs_pkg::cmd_t                  cmd,
  input  wire logic [$clog2(MAX_BOXES)-1:0]   wr_idx,
  input  wire logic [$clog2(MAX_BOXES)-1:0]   rd_idx,
  input  wire logic [15:0]                    iou_threshold,
  input  wire logic [15:0]                    score,
  input  wire logic signed [15:0]             x_min,
  input  wire logic signed [15:0]             y_min,
  input  wire logic signed [15:0]             x_max,
  input  wire logic signed [15:0]             y_max,
  output gbs_pkg::status_t                    status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [15:0]                         kept_score,
  output logic signed [15:0]                  kept_x_min,
  output logic signed [15:0]                  kept_y_min,
  output logic signed [15:0]                  kept_x_max,
  output logic signed [15:0]                  kept_y_max,
  output logic                                last_kept,
  output logic                                none_kept,
  output logic                                overflowed
);
  localparam int IDX_W  = $clog2(MAX_BOXES);
  localparam int SW     = gbs_pkg::SCORE_W;
  localparam int EW     = gbs_pkg::EDGE_W;
  localparam int BW     = gbs_pkg::BOX_W;
  localparam int DW     = gbs_pkg::DIFF_W;
  localparam int PW     = gbs_pkg::PROD_W;
  localparam int UW     = gbs_pkg::UNI_W;
  localparam int LW     = gbs_pkg::LO_W;
  localparam int PLW    = gbs_pkg::PLO_W;
  localparam int PHW    = gbs_pkg::PHI_W;
  localparam int CW     = gbs_pkg::CMP_W;

  // Box memories, one read port shared by search and suppression
  logic [SW-1:0] score_mem [MAX_BOXES];
  logic [BW-1:0] edge_mem  [MAX_BOXES];
  logic [SW-1:0] score_rd;
  logic [BW-1:0] edge_rd;
  logic [IDX_W-1:0] addr;

  logic [IDX_W-1:0] best_idx;
  logic [SW-1:0]    best_score;
  logic             best_found;
  assign addr = cmd.rd_best ? best_idx : rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_box) begin
      score_mem[wr_idx] <= score;
      edge_mem[wr_idx]  <= {y_max, x_max, y_min, x_min};
    end
    score_rd <= score_mem[addr];
    edge_rd  <= edge_mem[addr];
  end

  // Retired or suppressed marks, overflow flag
  logic [MAX_BOXES-1:0] dead;
  logic                 ovf;

  // Best-score search: highest score, lowest index on ties
  logic             sel_v;
  logic [IDX_W-1:0] sel_j;
  logic             sel_take;
  assign sel_take = sel_v && !dead[sel_j] && (score_rd != '0)
                    && (!best_found || (score_rd > best_score));

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v      <= 1'b0;
      best_found <= 1'b0;
    end else begin
      sel_v <= cmd.sel_issue;
      if (sel_take) best_found <= 1'b1;
      if (cmd.clear_best || cmd.finish) best_found <= 1'b0;
    end
    sel_j <= addr;
    if (sel_take) begin
      best_idx   <= sel_j;
      best_score <= score_rd;
    end
  end

  // Current top box
  logic [SW-1:0]        a_score;
  logic signed [EW-1:0] ax0, ay0, ax1, ay1;
  logic signed [PW-1:0] area_a;

  // Overlap pipeline stage registers
  logic                 v0, v1, v2, v3, v4;
  logic [IDX_W-1:0]     j0, j1, j2, j3, j4;
  logic signed [DW-1:0] bw1, bh1, iw1, ih1;
  logic signed [PW-1:0] ab2, ov2, ov3, ov4;
  logic                 pos2, pos3, pos4;
  logic signed [UW-1:0] uni3;
  logic [PLW-1:0]       plo4;
  logic signed [PHW-1:0] phi4;

  // Stage 1 combinational: intersection edges
  logic signed [EW-1:0] bx0, by0, bx1, by1, mx0, my0, mx1, my1;
  always_comb begin
    bx0 = edge_rd[EW-1:0];
    by0 = edge_rd[2*EW-1:EW];
    bx1 = edge_rd[3*EW-1:2*EW];
    by1 = edge_rd[4*EW-1:3*EW];
    mx0 = (ax0 > bx0) ? ax0 : bx0;
    my0 = (ay0 > by0) ? ay0 : by0;
    mx1 = (ax1 < bx1) ? ax1 : bx1;
    my1 = (ay1 < by1) ? ay1 : by1;
  end

  // Final compare: overlap * 2^16 against threshold * union
  logic signed [CW-1:0] lhs, rhs;
  logic                 hit;
  always_comb begin
    lhs = CW'(ov4) <<< 16;
    rhs = (CW'(phi4) <<< LW) + CW'($signed({1'b0, plo4}));
    hit = v4 && pos4 && (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4} <= '0;
    end else begin
      {v0, v1, v2, v3, v4} <= {cmd.supp_issue, v0, v1, v2, v3};
    end
    j0 <= addr;
    j1 <= j0;
    j2 <= j1;
    j3 <= j2;
    j4 <= j3;
    // box widths and intersection size
    bw1 <= DW'(bx1) - DW'(bx0);
    bh1 <= DW'(by1) - DW'(by0);
    iw1 <= DW'(mx1) - DW'(mx0);
    ih1 <= DW'(my1) - DW'(my0);
    // areas
    ab2  <= PW'(bw1) * PW'(bh1);
    ov2  <= PW'(iw1) * PW'(ih1);
    pos2 <= (iw1 > 0) && (ih1 > 0);
    // union
    uni3 <= UW'(area_a) + UW'(ab2) - UW'(ov2);
    ov3  <= ov2;
    pos3 <= pos2;
    // threshold times union, split in two partial products
    plo4 <= PLW'(iou_threshold) * PLW'(uni3[LW-1:0]);
    phi4 <= PHW'($signed({1'b0, iou_threshold})) * PHW'($signed(uni3[UW-1:LW]));
    ov4  <= ov3;
    pos4 <= pos3;
  end

  assign status.supp_busy  = v0 | v1 | v2 | v3 | v4;
  assign status.best_found = best_found;
  assign status.out_busy   = out_valid;

  // Marks and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      dead <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.rd_best) dead[best_idx] <= 1'b1;
      if (hit) dead[j4] <= 1'b1;
      if (cmd.finish) begin
        dead <= '0;
        ovf  <= 1'b0;
      end
    end
  end

  // Top box registers
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_score <= score_rd;
      ax0 <= edge_rd[EW-1:0];
      ay0 <= edge_rd[2*EW-1:EW];
      ax1 <= edge_rd[3*EW-1:2*EW];
      ay1 <= edge_rd[4*EW-1:3*EW];
    end
    if (cmd.area_step) area_a <= PW'(DW'(ax1) - DW'(ax0)) * PW'(DW'(ay1) - DW'(ay0));
  end

  // One survivor held back so the last one can be marked
  logic                 pend_valid;
  logic [SW-1:0]        pend_score;
  logic signed [EW-1:0] px0, py0, px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.area_step) begin
        pend_valid <= 1'b1;
        if (pend_valid) out_valid <= 1'b1;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
    if (cmd.area_step) begin
      pend_score <= a_score;
      px0 <= ax0;
      py0 <= ay0;
      px1 <= ax1;
      py1 <= ay1;
    end
    // result register
    if ((cmd.area_step && pend_valid) || (cmd.finish && pend_valid)) begin
      kept_score <= pend_score;
      kept_x_min <= px0;
      kept_y_min <= py0;
      kept_x_max <= px1;
      kept_y_max <= py1;
      last_kept  <= cmd.finish;
      none_kept  <= 1'b0;
      overflowed <= ovf;
    end else if (cmd.finish) begin
      kept_score <= '0;
      kept_x_min <= '0;
      kept_y_min <= '0;
      kept_x_max <= '0;
      kept_y_max <= '0;
      last_kept  <= 1'b1;
      none_kept  <= 1'b1;
      overflowed <= ovf;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/greedy_box_suppression_unit.sv =====
// Top level of the greedy box suppression unit.
//
// Boxes load at one item per cycle into an on-chip store of MAX_BOXES entries
// until an item with final_box set; items past capacity are dropped and the
// set's results carry overflowed. After the last box the unit takes no input
// until the set's final result is loaded into the output register. Processing
// of a set of n boxes with k survivors runs k+1 best-score searches and k overlap
// scans, each paced by the single read port of the box store; a result waits in
// the output register while the next search runs. Survivors come out highest
// score first, the last one marked last_kept; if none survive, one result with
// none_kept set is given. iou_threshold sits at byte address 0 of the register
// port, unsigned Q0.16.
`default_nettype none
module greedy_box_suppression_unit #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  gbs_box_if.sink                            boxes,
  gbs_kept_if.source                         kept,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [gbs_pkg::PDATA_W-1:0]   pwdata,
  output logic [gbs_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  localparam int IDX_W = $clog2(MAX_BOXES);

  // Threshold register
  logic [gbs_pkg::SCORE_W-1:0] iou_threshold;
  logic                        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == gbs_pkg::REG_IOU_THRESHOLD) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? gbs_pkg::PDATA_W'(iou_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= gbs_pkg::IOU_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      iou_threshold <= pwdata[gbs_pkg::SCORE_W-1:0];
    end
  end

  gbs_pkg::cmd_t    cmd;
  gbs_pkg::status_t status;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  gbs_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (boxes.valid),
    .in_final (boxes.final_box),
    .in_ready (boxes.ready),
    .status   (status),
    .cmd      (cmd),
    .wr_idx   (wr_idx),
    .rd_idx   (rd_idx)
  );

  gbs_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .wr_idx        (wr_idx),
    .rd_idx        (rd_idx),
    .iou_threshold (iou_threshold),
    .score         (boxes.score),
    .x_min         (boxes.x_min),
    .y_min         (boxes.y_min),
    .x_max         (boxes.x_max),
    .y_max         (boxes.y_max),
    .status        (status),
    .out_valid     (kept.valid),
    .out_ready     (kept.ready),
    .kept_score    (kept.kept_score),
    .kept_x_min    (kept.kept_x_min),
    .kept_y_min    (kept.kept_y_min),
    .kept_x_max    (kept.kept_x_max),
    .kept_y_max    (kept.kept_y_max),
    .last_kept     (kept.last_kept),
    .none_kept     (kept.none_kept),
    .overflowed    (kept.overflowed)
  );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the greedy box suppression unit: directed table plus random sets.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [15:0] score;
    logic signed [15:0] x0, y0, x1, y1;
    logic last;
  } box_t;

  typedef struct {
    logic [15:0] score;
    logic signed [15:0] x0, y0, x1, y1;
    logic last, none, ovf;
  } kept_t;

  // directed row: box plus optionally a typed-in expectation for a one-box set
  typedef struct {
    box_t b;
    logic has_exp;
    kept_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gbs_pkg::PADDR_W-1:0] paddr = '0;
  logic [gbs_pkg::PDATA_W-1:0] pwdata = '0;
  logic [gbs_pkg::PDATA_W-1:0] prdata;
  logic pready;

  gbs_box_if boxes();
  gbs_kept_if kept();

  greedy_box_suppression_unit #(.MAX_BOXES(NBOX)) uut (
    .clk(clk), .rst(rst), .boxes(boxes.sink), .kept(kept.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] thr = gbs_pkg::IOU_THRESHOLD_RESET;
  box_t set_boxes[$];
  logic set_ovf = 1'b0;
  kept_t kept_expect[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit idle_ok = 1'b1;
  bit typed_pending = 1'b0;
  kept_t typed_exp;

  function automatic bit too_close(box_t a, box_t b, logic [15:0] t);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, aa, ab, ix0, ix1, iy0, iy1, ov, un;
    ax0 = a.x0; ay0 = a.y0; ax1 = a.x1; ay1 = a.y1;
    bx0 = b.x0; by0 = b.y0; bx1 = b.x1; by1 = b.y1;
    aa = (ax1 - ax0) * (ay1 - ay0);
    ab = (bx1 - bx0) * (by1 - by0);
    ix0 = ax0 > bx0 ? ax0 : bx0;
    ix1 = ax1 < bx1 ? ax1 : bx1;
    iy0 = ay0 > by0 ? ay0 : by0;
    iy1 = ay1 < by1 ? ay1 : by1;
    if (ix0 >= ix1 || iy0 >= iy1) return 1'b0;
    ov = (ix1 - ix0) * (iy1 - iy0);
    un = aa + ab - ov;
    return ov * 65536 > longint'(t) * un;
  endfunction

  // accept one box into the predicted set; on the last box, predict survivors
  task automatic predict_box(box_t b);
    int rank[$];
    bit gone[NBOX];
    int n, j;
    kept_t k;
    if (set_boxes.size() < NBOX) set_boxes.insert(set_boxes.size(), b);
    else set_ovf = 1'b1;
    if (!b.last) return;
    n = set_boxes.size();
    for (int i = 0; i < n; i++) begin
      j = rank.size();
      while (j > 0 && set_boxes[rank[j-1]].score < set_boxes[i].score) j--;
      rank.insert(j, i);
    end
    for (int i = 0; i < n; i++) gone[i] = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (gone[rank[i]] || set_boxes[rank[i]].score == 0) continue;
      for (int m = i + 1; m < n; m++)
        if (!gone[rank[m]] && too_close(set_boxes[rank[i]], set_boxes[rank[m]], thr))
          gone[rank[m]] = 1'b1;
    end
    j = 0;
    for (int i = 0; i < n; i++) begin
      if (gone[rank[i]] || set_boxes[rank[i]].score == 0) continue;
      k.score = set_boxes[rank[i]].score;
      k.x0 = set_boxes[rank[i]].x0; k.y0 = set_boxes[rank[i]].y0;
      k.x1 = set_boxes[rank[i]].x1; k.y1 = set_boxes[rank[i]].y1;
      k.last = 1'b0; k.none = 1'b0; k.ovf = set_ovf;
      kept_expect.insert(kept_expect.size(), k);
      j++;
    end
    if (j == 0) begin
      k = '{16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, set_ovf};
      kept_expect.insert(kept_expect.size(), k);
    end else begin
      kept_expect[kept_expect.size()-1].last = 1'b1;
    end
    set_boxes.delete();
    set_ovf = 1'b0;
  endtask

  // output side: random stall, long hold-off when requested
  initial begin
    kept.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        kept.ready <= 1'b0;
      end else begin
        kept.ready <= !idle_ok || ($urandom_range(99) >= 10);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && kept.valid && kept.ready) begin
      if (kept_expect.size() == 0) begin
        $display("%0t: unexpected result score=%h", $time, kept.kept_score);
        errors <= errors + 1;
      end else begin
        kept_t e;
        e = kept_expect.pop_front();
        if (typed_pending && e.last) begin
          if (typed_exp != e) begin
            $display("%0t: typed row mismatch exp=%p pred=%p", $time, typed_exp, e);
            errors <= errors + 1;
          end
          typed_pending <= 1'b0;
        end
        if (e.score !== kept.kept_score || e.x0 !== kept.kept_x_min ||
            e.y0 !== kept.kept_y_min || e.x1 !== kept.kept_x_max ||
            e.y1 !== kept.kept_y_max || e.last !== kept.last_kept ||
            e.none !== kept.none_kept || e.ovf !== kept.overflowed) begin
          $display("%0t: mismatch exp=%p act=%h %h %h %h %h %b %b %b", $time, e,
                   kept.kept_score, kept.kept_x_min, kept.kept_y_min, kept.kept_x_max,
                   kept.kept_y_max, kept.last_kept, kept.none_kept, kept.overflowed);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_box(box_t b);
    while (idle_ok && $urandom_range(99) < 10) begin
      boxes.valid <= 1'b0;
      @(posedge clk);
    end
    boxes.valid <= 1'b1;
    boxes.score <= b.score;
    boxes.x_min <= b.x0; boxes.y_min <= b.y0;
    boxes.x_max <= b.x1; boxes.y_max <= b.y1;
    boxes.final_box <= b.last;
    @(posedge clk);
    while (!boxes.ready) @(posedge clk);
    predict_box(b);
  endtask

  task automatic drain();
    boxes.valid <= 1'b0;
    @(posedge clk);
    while (kept_expect.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_thr(logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= gbs_pkg::PADDR_W'(4 * gbs_pkg::REG_IOU_THRESHOLD); pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr = v;
  endtask

  function automatic box_t rand_box(bit lst, int spread);
    box_t b;
    int cx, cy;
    cx = $urandom_range(2 * spread) - spread;
    cy = $urandom_range(2 * spread) - spread;
    b.score = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535));
    if ($urandom_range(7) == 0) b.score = 16'd1000;
    if ($urandom_range(15) == 0) begin
      b.x0 = 16'($urandom); b.y0 = 16'($urandom);
      b.x1 = 16'($urandom); b.y1 = 16'($urandom);
    end else begin
      b.x0 = 16'(cx); b.y0 = 16'(cy);
      b.x1 = 16'(cx + $urandom_range(200)); b.y1 = 16'(cy + $urandom_range(200));
    end
    b.last = lst;
    return b;
  endfunction

  row_t dir_rows[$];
  int items;

  task automatic add_row(row_t x);
    dir_rows.insert(dir_rows.size(), x);
  endtask

  initial begin
    box_t b;
    row_t r;
    int n;
    boxes.valid <= 1'b0; boxes.score <= '0; boxes.x_min <= '0; boxes.y_min <= '0;
    boxes.x_max <= '0; boxes.y_max <= '0; boxes.final_box <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: single sets with typed expectations, then small sets
    r.has_exp = 1'b1;
    r.b = '{16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1};
    r.e = '{16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0};
    add_row(r);
    r.b = '{16'h0000, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 1'b1};
    r.e = '{16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0};
    add_row(r);
    r.b = '{16'h0001, 16'sd50, 16'sd50, 16'sd10, 16'sd10, 1'b1};
    r.e = '{16'h0001, 16'sd50, 16'sd50, 16'sd10, 16'sd10, 1'b1, 1'b0, 1'b0};
    add_row(r);
    r.has_exp = 1'b0;
    // equal scores, identical boxes: second suppressed
    r.b = '{16'd500, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd500, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b1}; add_row(r);
    // chain: middle suppressed by the first; the third is kept and suppresses the last
    r.b = '{16'd900, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd800, 16'sd40, 16'sd0, 16'sd140, 16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd700, 16'sd90, 16'sd0, 16'sd190, 16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd0, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd600, -16'sd10, -16'sd10, -16'sd100, -16'sd100, 1'b0}; add_row(r);
    r.b = '{16'd300, 16'sd100, 16'sd0, 16'sd200, 16'sd100, 1'b1}; add_row(r);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        typed_exp = dir_rows[i].e;
        typed_pending = 1'b1;
      end
      send_box(dir_rows[i].b);
      if (dir_rows[i].has_exp) drain();
    end
    drain();

    // overflow: 66 boxes, the last two dropped
    for (int i = 0; i < NBOX + 2; i++) send_box(rand_box(i == NBOX + 1, 300));
    drain();

    // random sets over several thresholds, extremes included
    items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_thr(16'd0);
        1: write_thr(16'hFFFF);
        2: write_thr(16'($urandom));
        3: write_thr(16'd13107);
        default: write_thr(16'd26214);
      endcase
      idle_ok = (ph != 2);
      for (int s = 0; s < 6; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8);
        if (ph == 4 && s == 0) hold_off = 300;
        for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1, 80));
        items += n;
        if (s == 2) drain();
      end
      drain();
    end
    idle_ok = 1'b1;
    drain();
    if (errors == 0 && kept_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
